### design/fbr_pkg.sv
package fbr_pkg;

	localparam int WORD_W          = 32;
	localparam int FRAME_WORDS     = 4;
	localparam int PARTS           = 4;
	localparam int MAX_FILL_BLOCKS = 15;

	localparam int SEQ_W     = 12;
	localparam int LIM_W     = SEQ_W + 1;
	localparam int PIDX_W    = 8;
	localparam int PART_W    = $clog2(PARTS);
	localparam int ROW_W     = FRAME_WORDS * WORD_W;
	localparam int FILL_CAP  = MAX_FILL_BLOCKS + 1;
	localparam int BLK_W     = $clog2(FILL_CAP);
	localparam int DIST_W    = LIM_W + 1;

	localparam logic [LIM_W-1:0] SEQ_SPACE       = LIM_W'(1 << SEQ_W);
	localparam logic [LIM_W-1:0] SEQ_LIMIT_RESET = LIM_W'(2048);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_RD,
		ST_LD,
		ST_OUT,
		ST_WR
	} state_t;

	typedef struct packed {
		logic              drop;
		logic              flush;
		logic              trunc;
		logic [BLK_W-1:0]  blocks_last;
		logic [SEQ_W-1:0]  adv_seq;
	} seq_info_t;

endpackage

### design/fbr_ram.sv
module fbr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/fbr_seq.sv
module fbr_seq (
	input  logic [fbr_pkg::SEQ_W-1:0] exp_seq,
	input  logic [fbr_pkg::SEQ_W-1:0] seq,
	input  logic [fbr_pkg::LIM_W-1:0] lim,
	output fbr_pkg::seq_info_t        info
);

	logic [fbr_pkg::DIST_W-1:0] sum;
	logic [fbr_pkg::DIST_W-1:0] gap;
	logic [fbr_pkg::DIST_W-1:0] blocks;
	logic [fbr_pkg::LIM_W-1:0]  nxt;

	always_comb begin
		// forward distance modulo the limit; a stale expected value beyond the limit wraps first
		sum = fbr_pkg::DIST_W'(seq) + fbr_pkg::DIST_W'(lim) - fbr_pkg::DIST_W'(exp_seq);
		if (fbr_pkg::LIM_W'(exp_seq) >= lim) begin
			gap = fbr_pkg::DIST_W'(seq) + fbr_pkg::DIST_W'(1);
		end else if (sum >= fbr_pkg::DIST_W'(lim)) begin
			gap = sum - fbr_pkg::DIST_W'(lim);
		end else begin
			gap = sum;
		end

		info.drop  = fbr_pkg::LIM_W'(seq) >= lim;
		info.flush = exp_seq != seq;
		info.trunc = gap > fbr_pkg::DIST_W'(fbr_pkg::FILL_CAP);
		blocks     = info.trunc ? fbr_pkg::DIST_W'(fbr_pkg::FILL_CAP) : gap;
		info.blocks_last = fbr_pkg::BLK_W'(blocks - fbr_pkg::DIST_W'(1));

		nxt = fbr_pkg::LIM_W'(exp_seq) + fbr_pkg::LIM_W'(1);
		info.adv_seq = (nxt >= lim) ? '0 : nxt[fbr_pkg::SEQ_W-1:0];
	end

endmodule

### design/frame_to_block_reassembly.sv
// A frame that only stores data passes ST_CHK and ST_WR between accept and the next accept.
// The first result of a flush is offered in ST_OUT, after ST_CHK, ST_RD and ST_LD.
// A flushing frame passes ST_RD, ST_LD and ST_OUT, plus output stalls, for each part of
// its blocks, the current one and up to 15 zero blocks; each result needs one store read.
// One frame is in work at a time; the store is a 4-row RAM of 128-bit rows.
// Reset clears the row valid bits at once, so the store reads as zero with no
// clearing pass; expected sequence resets to 0 and seq_limit to 2048.
module frame_to_block_reassembly (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fbr_pkg::LIM_W-1:0]          cfg_data,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [fbr_pkg::SEQ_W-1:0]          pkt_seq,
	input  logic [fbr_pkg::PIDX_W-1:0]         part_index,
	input  logic [fbr_pkg::WORD_W-1:0]         in_word0,
	input  logic [fbr_pkg::WORD_W-1:0]         in_word1,
	input  logic [fbr_pkg::WORD_W-1:0]         in_word2,
	input  logic [fbr_pkg::WORD_W-1:0]         in_word3,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [fbr_pkg::SEQ_W-1:0]          out_seq,
	output logic [fbr_pkg::PART_W-1:0]         out_part,
	output logic [fbr_pkg::WORD_W-1:0]         out_word0,
	output logic [fbr_pkg::WORD_W-1:0]         out_word1,
	output logic [fbr_pkg::WORD_W-1:0]         out_word2,
	output logic [fbr_pkg::WORD_W-1:0]         out_word3,
	output logic                               block_end,
	output logic                               burst_end,
	output logic                               gap_truncated
);

	fbr_pkg::state_t state_q, state_d;

	logic [fbr_pkg::LIM_W-1:0]  seq_limit_q;
	logic [fbr_pkg::LIM_W-1:0]  lim;
	logic [fbr_pkg::SEQ_W-1:0]  exp_q;
	logic [fbr_pkg::PARTS-1:0]  vld_q;
	logic [fbr_pkg::PART_W-1:0] part_cnt_q;
	logic [fbr_pkg::BLK_W-1:0]  blk_q;

	logic [fbr_pkg::SEQ_W-1:0]  seq_q;
	logic [fbr_pkg::PIDX_W-1:0] part_q;
	logic [fbr_pkg::ROW_W-1:0]  row_q;
	logic [fbr_pkg::BLK_W-1:0]  blocks_last_q;
	logic                       trunc_q;
	logic [fbr_pkg::ROW_W-1:0]  out_row_q;
	logic [fbr_pkg::SEQ_W-1:0]  out_seq_q;
	logic [fbr_pkg::PART_W-1:0] out_part_q;
	logic                       block_end_q;
	logic                       burst_end_q;
	logic                       gap_q;

	fbr_pkg::seq_info_t         info;
	logic [fbr_pkg::ROW_W-1:0]  rdata;
	logic                       part_ok;
	logic                       last_part;
	logic                       last_blk;
	logic                       ram_we;

	assign lim       = (seq_limit_q > fbr_pkg::SEQ_SPACE) ? fbr_pkg::SEQ_SPACE : seq_limit_q;
	assign part_ok   = part_q < fbr_pkg::PIDX_W'(fbr_pkg::PARTS);
	assign last_part = part_cnt_q == fbr_pkg::PART_W'(fbr_pkg::PARTS - 1);
	assign last_blk  = blk_q == blocks_last_q;
	assign cfg_ready = 1'b1;

	fbr_seq u_seq (
		.exp_seq (exp_q),
		.seq     (seq_q),
		.lim     (lim),
		.info    (info)
	);

	fbr_ram #(
		.WIDTH (fbr_pkg::ROW_W),
		.DEPTH (fbr_pkg::PARTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (part_q[fbr_pkg::PART_W-1:0]),
		.wdata (row_q),
		.raddr (part_cnt_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		ram_we    = 1'b0;
		unique case (state_q)
			fbr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = fbr_pkg::ST_CHK;
				end
			end
			fbr_pkg::ST_CHK: begin
				if (info.drop) begin
					state_d = fbr_pkg::ST_IDLE;
				end else if (info.flush) begin
					state_d = fbr_pkg::ST_RD;
				end else begin
					state_d = fbr_pkg::ST_WR;
				end
			end
			fbr_pkg::ST_RD: state_d = fbr_pkg::ST_LD;
			fbr_pkg::ST_LD: state_d = fbr_pkg::ST_OUT;
			fbr_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = (last_part && last_blk) ? fbr_pkg::ST_WR : fbr_pkg::ST_RD;
				end
			end
			fbr_pkg::ST_WR: begin
				ram_we  = part_ok;
				state_d = fbr_pkg::ST_IDLE;
			end
			default: state_d = fbr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_limit_q <= fbr_pkg::SEQ_LIMIT_RESET;
			exp_q       <= '0;
			vld_q       <= '0;
			part_cnt_q  <= '0;
			blk_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seq_limit_q <= cfg_data;
			end
			case (state_q)
				fbr_pkg::ST_CHK: begin
					part_cnt_q <= '0;
					blk_q      <= '0;
				end
				fbr_pkg::ST_OUT: begin
					if (!out_stall) begin
						if (last_part) begin
							// block done: advance sequence, store now reads as zero
							part_cnt_q <= '0;
							blk_q      <= blk_q + fbr_pkg::BLK_W'(1);
							exp_q      <= info.adv_seq;
							vld_q      <= '0;
						end else begin
							part_cnt_q <= part_cnt_q + fbr_pkg::PART_W'(1);
						end
					end
				end
				fbr_pkg::ST_WR: begin
					exp_q <= seq_q;
					if (part_ok) begin
						vld_q[part_q[fbr_pkg::PART_W-1:0]] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			seq_q  <= pkt_seq;
			part_q <= part_index;
			row_q  <= {in_word3, in_word2, in_word1, in_word0};
		end
		if (state_q == fbr_pkg::ST_CHK) begin
			blocks_last_q <= info.blocks_last;
			trunc_q       <= info.trunc;
		end
		if (state_q == fbr_pkg::ST_LD) begin
			// only the first block of a burst carries stored data
			out_row_q   <= (blk_q == '0 && vld_q[part_cnt_q]) ? rdata : '0;
			out_seq_q   <= exp_q;
			out_part_q  <= part_cnt_q;
			block_end_q <= last_part;
			burst_end_q <= last_part && last_blk;
			gap_q       <= trunc_q;
		end
	end

	assign out_seq       = out_seq_q;
	assign out_part      = out_part_q;
	assign out_word0     = out_row_q[0*fbr_pkg::WORD_W +: fbr_pkg::WORD_W];
	assign out_word1     = out_row_q[1*fbr_pkg::WORD_W +: fbr_pkg::WORD_W];
	assign out_word2     = out_row_q[2*fbr_pkg::WORD_W +: fbr_pkg::WORD_W];
	assign out_word3     = out_row_q[3*fbr_pkg::WORD_W +: fbr_pkg::WORD_W];
	assign block_end     = block_end_q;
	assign burst_end     = burst_end_q;
	assign gap_truncated = gap_q;

endmodule

### design/fbr_chk.sv
module fbr_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [fbr_pkg::PART_W-1:0] out_part,
	input logic                       block_end,
	input logic                       burst_end
);

	// one item in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while one is in work");

	// no new item is taken while results are pending
	a_no_accept_during_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while results pending");

	a_burst_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && burst_end) |=> !out_valid)
		else $error("result after end of burst");

	a_block_end_last_part: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (block_end == (out_part == fbr_pkg::PART_W'(fbr_pkg::PARTS - 1))))
		else $error("block_end not on last part");

	a_burst_on_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && burst_end) |-> block_end)
		else $error("burst ends inside a block");

endmodule

bind frame_to_block_reassembly fbr_chk u_fbr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_part  (out_part),
	.block_end (block_end),
	.burst_end (burst_end)
);
